/* src/md5_pkg.sv */
package md5_pkg;

  // field widths
  localparam int WORD_W  = 32;
  localparam int LEN_W   = 64;
  localparam int NBYTE_W = 3;

  // command queue depth
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // command kinds from the front
  localparam logic [1:0] CMD_WORD      = 2'd0;
  localparam logic [1:0] CMD_LAST_FULL = 2'd1;
  localparam logic [1:0] CMD_LAST_PART = 2'd2;

  // back-end sequencer states
  localparam logic [2:0] ST_TAKE  = 3'd0;
  localparam logic [2:0] ST_PAD   = 3'd1;
  localparam logic [2:0] ST_ROUND = 3'd2;
  localparam logic [2:0] ST_ADD   = 3'd3;
  localparam logic [2:0] ST_EMIT  = 3'd4;

  // initial chaining values
  localparam logic [31:0] IV_A = 32'h67452301;
  localparam logic [31:0] IV_B = 32'hEFCDAB89;
  localparam logic [31:0] IV_C = 32'h98BADCFE;
  localparam logic [31:0] IV_D = 32'h10325476;

  localparam logic [31:0] PAD_BYTE = 32'h00000080;

  // round constants
  localparam logic [31:0] K_TABLE [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  // rotate amounts, indexed by {stage, round[1:0]}
  localparam logic [4:0] ROT_TABLE [16] = '{
    5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
  };

  // one command between front and back
  typedef struct packed {
    logic [LEN_W-1:0]  bit_len;
    logic [1:0]        kind;
    logic [WORD_W-1:0] word;
  } md5_cmd_t;

  // back-end status for checking
  typedef struct packed {
    logic [2:0] state;
    logic [3:0] slot;
    logic [5:0] round;
  } md5_status_t;

  // message word index for a round
  function automatic logic [3:0] msg_index(input logic [5:0] i);
    logic [3:0] j;
    j = i[3:0];
    case (i[5:4])
      2'd0:    msg_index = j;
      2'd1:    msg_index = 4'(j * 4'd5 + 4'd1);
      2'd2:    msg_index = 4'(j * 4'd3 + 4'd5);
      default: msg_index = 4'(j * 4'd7);
    endcase
  endfunction

endpackage

/* src/md5_front.sv */
module md5_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [39:0]       in_tdata,   // message_word[31:0], valid_bytes[34:32]
  input  logic              in_tlast,   // last_word
  output logic              cmd_valid,
  input  logic              cmd_ready,
  output md5_pkg::md5_cmd_t cmd
);
  import md5_pkg::*;

  logic [LEN_W-1:0]   count_r, count_nxt;
  logic [NBYTE_W-1:0] nbytes;
  logic [WORD_W-1:0]  word;
  logic [WORD_W-1:0]  keep;
  logic [LEN_W-1:0]   total;
  logic               accept;

  assign in_tready = cmd_ready;
  assign cmd_valid = in_tvalid;
  assign accept    = in_tvalid && cmd_ready;
  assign word      = in_tdata[31:0];

  // clamp byte count of the last word
  always_comb begin
    nbytes = (in_tdata[34:32] > 3'd4) ? 3'd4 : in_tdata[34:32];
    case (nbytes[1:0])
      2'd0:    keep = 32'h00000000;
      2'd1:    keep = 32'h000000FF;
      2'd2:    keep = 32'h0000FFFF;
      default: keep = 32'h00FFFFFF;
    endcase
    total = count_r + {{(LEN_W-6){1'b0}}, nbytes, 3'b000};
  end

  // classify the word into a command
  always_comb begin
    cmd.bit_len = total;
    if (!in_tlast) begin
      cmd.kind = CMD_WORD;
      cmd.word = word;
    end else if (nbytes == 3'd4) begin
      cmd.kind = CMD_LAST_FULL;
      cmd.word = word;
    end else begin
      cmd.kind = CMD_LAST_PART;
      cmd.word = (word & keep) | (PAD_BYTE << {nbytes[1:0], 3'b000});
    end
  end

  // running message length in bits
  always_comb begin
    count_nxt = count_r;
    if (accept) begin
      if (in_tlast) begin
        count_nxt = '0;
      end else begin
        count_nxt = count_r + LEN_W'(32);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

endmodule

/* src/md5_cmd_queue.sv */
module md5_cmd_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  output logic              push_ready,
  input  md5_pkg::md5_cmd_t push_cmd,
  output logic              pop_valid,
  input  logic              pop_ready,
  output md5_pkg::md5_cmd_t pop_cmd
);
  import md5_pkg::*;

  md5_cmd_t           slots_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] fill_r, fill_nxt;
  logic               do_push, do_pop;

  assign push_ready = (fill_r != Q_CNT_W'(Q_DEPTH));
  assign pop_valid  = (fill_r != '0);
  assign pop_cmd    = slots_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // pointer and fill update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    fill_nxt = fill_r + Q_CNT_W'(do_push) - Q_CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

/* src/md5_back.sv */
module md5_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cmd_valid,
  output logic                 cmd_pop,
  input  md5_pkg::md5_cmd_t    cmd,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [127:0]         out_tdata,
  output md5_pkg::md5_status_t status
);
  import md5_pkg::*;

  // padding phases
  localparam logic [2:0] PH_MSG  = 3'd0;
  localparam logic [2:0] PH_80   = 3'd1;
  localparam logic [2:0] PH_ZERO = 3'd2;
  localparam logic [2:0] PH_HI   = 3'd3;
  localparam logic [2:0] PH_DONE = 3'd4;

  logic [2:0]        state_r, state_nxt;
  logic [2:0]        phase_r, phase_nxt;
  logic [3:0]        slot_r, slot_nxt;
  logic [5:0]        round_r, round_nxt;
  logic [31:0]       chain_r [4];
  logic [31:0]       chain_nxt [4];
  logic [31:0]       a_r, b_r, c_r, d_r;
  logic [31:0]       a_nxt, b_nxt, c_nxt, d_nxt;
  logic [31:0]       pre_r, pre_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [127:0]      out_data_r, out_data_nxt;
  logic [31:0]       buf_r [16];
  logic              push_en;
  logic [31:0]       push_data;
  logic [2:0]        phase_after;
  logic [5:0]        round_next;
  logic [3:0]        rd_idx;
  logic [31:0]       rd_word;
  logic [31:0]       mix, sum, rot;
  logic [4:0]        shamt;

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign status.state = state_r;
  assign status.slot  = slot_r;
  assign status.round = round_r;

  // block buffer read for the next round
  assign round_next = round_r + 6'd1;
  assign rd_idx     = (state_r == ST_ROUND) ? msg_index(round_next) : 4'd0;
  assign rd_word    = buf_r[rd_idx];

  // round function
  always_comb begin
    case (round_r[5:4])
      2'd0:    mix = (b_r & c_r) | (~b_r & d_r);
      2'd1:    mix = (d_r & b_r) | (~d_r & c_r);
      2'd2:    mix = b_r ^ c_r ^ d_r;
      default: mix = c_r ^ (b_r | ~d_r);
    endcase
    sum   = a_r + mix + pre_r;
    shamt = ROT_TABLE[{round_r[5:4], round_r[1:0]}];
    rot   = (sum << shamt) | (sum >> (6'd32 - {1'b0, shamt}));
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    slot_nxt      = slot_r;
    round_nxt     = round_r;
    chain_nxt     = chain_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    c_nxt         = c_r;
    d_nxt         = d_r;
    pre_nxt       = pre_r;
    len_nxt       = len_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    cmd_pop       = 1'b0;
    push_en       = 1'b0;
    push_data     = '0;
    phase_after   = phase_r;

    case (state_r)
      // take one command word from the queue
      ST_TAKE: begin
        if (cmd_valid) begin
          cmd_pop   = 1'b1;
          push_en   = 1'b1;
          push_data = cmd.word;
          len_nxt   = cmd.bit_len;
          case (cmd.kind)
            CMD_LAST_FULL: phase_after = PH_80;
            CMD_LAST_PART: phase_after = PH_ZERO;
            default:       phase_after = PH_MSG;
          endcase
        end
      end
      // generate padding and length words
      ST_PAD: begin
        push_en = 1'b1;
        case (phase_r)
          PH_80: begin
            push_data   = PAD_BYTE;
            phase_after = PH_ZERO;
          end
          PH_ZERO: begin
            if (slot_r == 4'd14) begin
              push_data   = len_r[31:0];
              phase_after = PH_HI;
            end
          end
          PH_HI: begin
            push_data   = len_r[63:32];
            phase_after = PH_DONE;
          end
          default: begin
            push_en = 1'b0;
          end
        endcase
      end
      // one compression round per cycle
      ST_ROUND: begin
        a_nxt     = d_r;
        d_nxt     = c_r;
        c_nxt     = b_r;
        b_nxt     = b_r + rot;
        pre_nxt   = K_TABLE[round_next] + rd_word;
        round_nxt = round_next;
        if (round_r == 6'd63) begin
          state_nxt = ST_ADD;
        end
      end
      // fold round words into the chaining values
      ST_ADD: begin
        chain_nxt[0] = chain_r[0] + a_r;
        chain_nxt[1] = chain_r[1] + b_r;
        chain_nxt[2] = chain_r[2] + c_r;
        chain_nxt[3] = chain_r[3] + d_r;
        if (phase_r == PH_MSG) begin
          state_nxt = ST_TAKE;
        end else if (phase_r == PH_DONE) begin
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_PAD;
        end
      end
      // hand the digest to the output register
      ST_EMIT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {chain_r[3], chain_r[2], chain_r[1], chain_r[0]};
          chain_nxt[0]  = IV_A;
          chain_nxt[1]  = IV_B;
          chain_nxt[2]  = IV_C;
          chain_nxt[3]  = IV_D;
          phase_nxt     = PH_MSG;
          state_nxt     = ST_TAKE;
        end
      end
      default: begin
        state_nxt = ST_TAKE;
      end
    endcase

    // a full block starts the compression
    if (push_en) begin
      phase_nxt = phase_after;
      slot_nxt  = slot_r + 4'd1;
      if (slot_r == 4'd15) begin
        state_nxt = ST_ROUND;
        round_nxt = '0;
        a_nxt     = chain_r[0];
        b_nxt     = chain_r[1];
        c_nxt     = chain_r[2];
        d_nxt     = chain_r[3];
        pre_nxt   = K_TABLE[0] + rd_word;
      end else if (phase_after == PH_MSG) begin
        state_nxt = ST_TAKE;
      end else begin
        state_nxt = ST_PAD;
      end
    end
  end

  // control and chaining registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_TAKE;
      phase_r     <= PH_MSG;
      slot_r      <= '0;
      round_r     <= '0;
      out_valid_r <= 1'b0;
      chain_r[0]  <= IV_A;
      chain_r[1]  <= IV_B;
      chain_r[2]  <= IV_C;
      chain_r[3]  <= IV_D;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      slot_r      <= slot_nxt;
      round_r     <= round_nxt;
      out_valid_r <= out_valid_nxt;
      chain_r     <= chain_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    c_r        <= c_nxt;
    d_r        <= d_nxt;
    pre_r      <= pre_nxt;
    len_r      <= len_nxt;
    out_data_r <= out_data_nxt;
    if (push_en) begin
      buf_r[slot_r] <= push_data;
    end
  end

endmodule

/* src/md5_message_digest.sv */
// channel | ports                            | transaction
// --------+----------------------------------+------------------------------------------
// input   | in_tvalid in_tready in_tdata     | one message word, valid_bytes, last_word
//         | in_tlast                         |
// output  | out_tvalid out_tready out_tdata  | 128-bit digest, one per message
//
// a block loads 16 words from the command queue, then runs 64 rounds on the single round
// unit and folds the round words into the chain; the queue takes new words meanwhile.
// the last word adds pad words, one a cycle except while a full block is compressed, and
// a second block when the length no longer fits; the emit step then moves the digest
// into the output register once it is free. reset (rst_n low, synchronous) empties the
// queue and loads the initial chain. the front and its two-entry queue take up to two
// words while the back is busy or while an untaken digest holds the output register.
module md5_message_digest (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [39:0]  in_tdata,    // message_word[31:0], valid_bytes[34:32]
  input  logic         in_tlast,    // last_word
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata    // digest_a, digest_b, digest_c, digest_d
);
  import md5_pkg::*;

  md5_cmd_t    front_cmd, q_cmd;
  logic        front_valid, front_ready;
  logic        q_valid, q_pop;
  md5_status_t st;

  // accept and classify words
  md5_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .cmd_valid (front_valid),
    .cmd_ready (front_ready),
    .cmd       (front_cmd)
  );

  // decoupling queue
  md5_cmd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_cmd   (front_cmd),
    .pop_valid  (q_valid),
    .pop_ready  (q_pop),
    .pop_cmd    (q_cmd)
  );

  // padding and compression
  md5_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (q_valid),
    .cmd_pop    (q_pop),
    .cmd        (q_cmd),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .status     (st)
  );

  // a digest appears only out of the emit step
  a_digest_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(st.state) == ST_EMIT)
    else $error("digest appeared outside emit");

  // rounds advance one per cycle without a break
  a_round_step: assert property (@(posedge clk) disable iff (!rst_n)
    (st.state == ST_ROUND && st.round != 6'd63) |=>
      (st.state == ST_ROUND && st.round == $past(st.round) + 6'd1))
    else $error("round sequence broken");

  // the buffer is empty again when a block is folded in
  a_slot_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    st.state == ST_ADD |-> st.slot == 4'd0)
    else $error("block folded with partial buffer");

  // the queue is drained only while loading words
  a_pop_in_take: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (st.state == ST_TAKE && q_valid))
    else $error("queue popped outside take");

endmodule
